@@ rtl/core/esi_pkg.sv @@
package esi_pkg;

  // channel store geometry
  localparam int CHANNELS       = 12;
  localparam int CH_W           = 4;
  localparam int AXIS_W         = 4;
  localparam int TIME_W         = 63;
  localparam int DEB_W          = 20;
  localparam int AXIS_COUNT_DEF = 6;

  localparam logic [DEB_W-1:0] DEB_RESET = DEB_W'(2000);
  localparam logic [CH_W-1:0]  LAST_CH   = CH_W'(CHANNELS - 1);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_HOMING = 2'd1,
    MODE_ESTOP  = 2'd2,
    MODE_FAULT  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    OP_NOTIFY    = 4'd0,
    OP_POLL      = 4'd1,
    OP_HOMING    = 4'd2,
    OP_RELEASE   = 4'd3,
    OP_ESTOP     = 4'd4,
    OP_FAULT     = 4'd5,
    OP_TRYCLEAR  = 4'd6,
    OP_QUERY     = 4'd7,
    OP_CLEAR     = 4'd8,
    OP_CONSUME   = 4'd9,
    OP_CLEARPEND = 4'd10,
    OP_FORCE     = 4'd11
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POLL,
    ST_DRIFT,
    ST_DONE
  } state_t;

  // one input item as seen by the sequencer
  typedef struct packed {
    logic [3:0]          opcode;
    logic [AXIS_W-1:0]   axis_index;
    logic                end_select;
    logic [TIME_W-1:0]   time_us;
    logic [CHANNELS-1:0] pressed_levels;
    logic                drift_present;
    logic                active;
  } item_t;

  // status handed from the sequencer to the output register
  typedef struct packed {
    mode_t               mode;
    logic [CHANNELS-1:0] latch;
    logic                reply;
    logic                clr_end;
    logic                clr_drift;
  } res_t;

  // channels whose axis lies below the axis count
  function automatic logic [CHANNELS-1:0] exist_mask(input int axes);
    logic [CHANNELS-1:0] m;
    m = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      m[i] = ((i / 2) < axes);
    end
    return m;
  endfunction

endpackage

@@ rtl/core/esi_in_if.sv @@
interface esi_in_if import esi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [3:0]          opcode;
  logic [AXIS_W-1:0]   axis_index;
  logic                end_select;
  logic [TIME_W-1:0]   time_us;
  logic [CHANNELS-1:0] pressed_levels;
  logic                drift_present;
  logic                active;

  modport source (
    output valid, opcode, axis_index, end_select, time_us, pressed_levels,
           drift_present, active,
    input  ready
  );
  modport sink (
    input  valid, opcode, axis_index, end_select, time_us, pressed_levels,
           drift_present, active,
    output ready
  );
endinterface

@@ rtl/core/esi_out_if.sv @@
interface esi_out_if import esi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          safety_mode;
  logic                motion_allowed;
  logic [CHANNELS-1:0] latch_bits;
  logic                any_latch;
  logic                reply_flag;
  logic                clear_endstop_strobe;
  logic                clear_drift_strobe;

  modport source (
    output valid, safety_mode, motion_allowed, latch_bits, any_latch, reply_flag,
           clear_endstop_strobe, clear_drift_strobe,
    input  ready
  );
  modport sink (
    input  valid, safety_mode, motion_allowed, latch_bits, any_latch, reply_flag,
           clear_endstop_strobe, clear_drift_strobe,
    output ready
  );
endinterface

@@ rtl/core/esi_cfg_if.sv @@
interface esi_cfg_if import esi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DEB_W-1:0] settle_time;

  modport source (
    output valid, settle_time,
    input  ready
  );
  modport sink (
    input  valid, settle_time,
    output ready
  );
endinterface

@@ rtl/core/esi_age_cmp.sv @@
module esi_age_cmp import esi_pkg::*; (
  input  logic [TIME_W-1:0] now,
  input  logic [TIME_W-1:0] edge_time,
  input  logic [DEB_W-1:0]  debounce,
  output logic              mature
);

  logic [TIME_W:0] diff;

  // age of the edge; the top bit is the borrow of an edge in the future
  assign diff = {1'b0, now} - {1'b0, edge_time};

  // old enough once the age reaches the debounce time
  assign mature = !diff[TIME_W] &&
                  ((|diff[TIME_W-1:DEB_W]) || (diff[DEB_W-1:0] >= debounce));

endmodule

@@ rtl/core/esi_ctrl.sv @@
module esi_ctrl import esi_pkg::*; #(
  parameter int AXIS_COUNT = AXIS_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  item_t            item,
  input  logic [DEB_W-1:0] debounce,
  input  logic             slot_free,
  output logic             idle,
  output logic             res_valid,
  output res_t             res
);

  localparam logic [CHANNELS-1:0] EXIST = exist_mask(AXIS_COUNT);

  state_t              state, state_next;
  logic [CH_W-1:0]     idx, idx_next;
  mode_t               mode, mode_next;
  logic                homing_on, homing_next;
  logic                release_on, release_next;
  logic [CHANNELS-1:0] pending, pending_next;
  logic [CHANNELS-1:0] latch, latch_next;
  logic                reply, reply_next;
  logic                clr_end, clr_end_next;
  logic                clr_drift, clr_drift_next;
  logic [TIME_W-1:0]   edge_times [CHANNELS];

  // captured item
  op_t                 op;
  logic [CH_W-1:0]     ch;
  logic                ch_ok;
  logic [TIME_W-1:0]   now;
  logic [CHANNELS-1:0] levels;
  logic                drift;
  logic                act;

  logic [CH_W:0]       ch_full;
  logic                mature;

  assign ch_full = {item.axis_index, item.end_select};

  // shared age compare, walked over the channels by idx
  esi_age_cmp u_age (
    .now       (now),
    .edge_time (edge_times[idx]),
    .debounce  (debounce),
    .mature    (mature)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      mode       <= MODE_NORMAL;
      homing_on  <= 1'b0;
      release_on <= 1'b0;
      pending    <= '0;
      latch      <= '0;
      reply      <= 1'b0;
      clr_end    <= 1'b0;
      clr_drift  <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      mode       <= mode_next;
      homing_on  <= homing_next;
      release_on <= release_next;
      pending    <= pending_next;
      latch      <= latch_next;
      reply      <= reply_next;
      clr_end    <= clr_end_next;
      clr_drift  <= clr_drift_next;
    end
  end

  // item capture and edge time store
  always_ff @(posedge clk) begin
    if (start) begin
      op     <= op_t'(item.opcode);
      ch     <= ch_full[CH_W-1:0];
      ch_ok  <= (ch_full < (CH_W+1)'(CHANNELS)) &&
                ({1'b0, item.axis_index} < (AXIS_W+1)'(AXIS_COUNT));
      now    <= item.time_us;
      levels <= item.pressed_levels;
      drift  <= item.drift_present;
      act    <= item.active;
    end
    if (state == ST_EXEC && op == OP_NOTIFY && ch_ok) begin
      edge_times[ch] <= now;
    end
  end

  // sequencer
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    mode_next      = mode;
    homing_next    = homing_on;
    release_next   = release_on;
    pending_next   = pending;
    latch_next     = latch;
    reply_next     = reply;
    clr_end_next   = clr_end;
    clr_drift_next = clr_drift;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next     = ST_EXEC;
          reply_next     = 1'b0;
          clr_end_next   = 1'b0;
          clr_drift_next = 1'b0;
        end
      end

      ST_EXEC: begin
        state_next = ST_DONE;
        unique case (op)
          OP_NOTIFY: begin
            if (ch_ok) pending_next[ch] = 1'b1;
          end
          OP_POLL: begin
            if (release_on) begin
              pending_next = '0;
              latch_next   = '0;
            end else begin
              idx_next   = '0;
              state_next = ST_POLL;
            end
          end
          OP_HOMING: begin
            homing_next = act;
            if (act && mode == MODE_NORMAL) mode_next = MODE_HOMING;
            else if (!act && mode == MODE_HOMING) mode_next = MODE_NORMAL;
          end
          OP_RELEASE: begin
            release_next = act;
            if (act) begin
              pending_next = '0;
              latch_next   = '0;
              if (mode == MODE_ESTOP) mode_next = MODE_NORMAL;
            end
          end
          OP_ESTOP: begin
            mode_next = MODE_ESTOP;
          end
          OP_FAULT: begin
            if (mode != MODE_FAULT && mode != MODE_ESTOP) mode_next = MODE_FAULT;
          end
          OP_TRYCLEAR: begin
            if (!(|(levels & EXIST))) begin
              pending_next   = '0;
              latch_next     = '0;
              clr_end_next   = 1'b1;
              clr_drift_next = 1'b1;
              mode_next      = MODE_NORMAL;
              homing_next    = 1'b0;
              reply_next     = 1'b1;
            end
          end
          OP_QUERY: begin
            if (ch_ok) reply_next = latch[ch];
          end
          OP_CLEAR: begin
            if (ch_ok) begin
              latch_next[ch]   = 1'b0;
              pending_next[ch] = 1'b0;
            end
          end
          OP_CONSUME: begin
            if (ch_ok) begin
              reply_next       = latch[ch];
              latch_next[ch]   = 1'b0;
              pending_next[ch] = 1'b0;
            end
          end
          OP_CLEARPEND: begin
            if (ch_ok) pending_next[ch] = 1'b0;
          end
          OP_FORCE: begin
            pending_next   = '0;
            latch_next     = '0;
            clr_drift_next = 1'b1;
            mode_next      = MODE_NORMAL;
            homing_next    = 1'b0;
          end
          default: begin
          end
        endcase
      end

      // one channel per cycle through the shared age compare
      ST_POLL: begin
        if (EXIST[idx] && pending[idx] && mature) begin
          if (levels[idx]) begin
            latch_next[idx] = 1'b1;
            if (!homing_on) mode_next = MODE_ESTOP;
            else if (mode == MODE_NORMAL) mode_next = MODE_HOMING;
          end
          pending_next[idx] = 1'b0;
        end
        if (idx == LAST_CH) state_next = ST_DRIFT;
        else idx_next = idx + CH_W'(1);
      end

      ST_DRIFT: begin
        if (drift && (mode == MODE_NORMAL || mode == MODE_HOMING)) mode_next = MODE_FAULT;
        state_next = ST_DONE;
      end

      ST_DONE: begin
        if (slot_free) state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign idle          = (state == ST_IDLE);
  assign res_valid     = (state == ST_DONE);
  assign res.mode      = mode;
  assign res.latch     = latch;
  assign res.reply     = reply;
  assign res.clr_end   = clr_end;
  assign res.clr_drift = clr_drift;

endmodule

@@ rtl/core/endstop_safety_interlock.sv @@
// Endstop safety interlock: one event per item on item_in, one status item per
// event on result_out, in the same order.
// The debounce time is written over cfg (always ready); write it only while
// no item is in flight. It resets to 2000 us.
// Every opcode but poll (and a poll under manual release) passes from the EXEC
// state to DONE and on into the output register; a poll instead walks the
// twelve channels one per cycle through a single age subtractor and compare,
// then checks drift.
// item_in.ready is high only while the sequencer is idle, so one item is in
// work at a time; the next item is taken only once the previous status has
// moved to the output register. An item may be taken while the
// previous status still waits in the output register.
// If result_out stalls, the finished status is held in the sequencer until
// the output register frees, and no new item is taken meanwhile.
// Synchronous reset (rst) gives mode normal, homing and release off, every
// pending flag and latch clear, and an empty output register.
module endstop_safety_interlock import esi_pkg::*; #(
  parameter int AXIS_COUNT = AXIS_COUNT_DEF
) (
  input logic       clk,
  input logic       rst,
  esi_in_if.sink    item_in,
  esi_out_if.source result_out,
  esi_cfg_if.sink   cfg
);

  logic [DEB_W-1:0] debounce;
  logic             start;
  logic             idle;
  logic             slot_free;
  logic             res_valid;
  item_t            item;
  res_t             res;
  res_t             out_res;
  logic             out_valid;

  // debounce register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce <= DEB_RESET;
    end else if (cfg.valid) begin
      debounce <= cfg.settle_time;
    end
  end

  // input handshake
  assign item_in.ready       = idle;
  assign start               = item_in.valid && idle;
  assign item.opcode         = item_in.opcode;
  assign item.axis_index     = item_in.axis_index;
  assign item.end_select     = item_in.end_select;
  assign item.time_us        = item_in.time_us;
  assign item.pressed_levels = item_in.pressed_levels;
  assign item.drift_present  = item_in.drift_present;
  assign item.active         = item_in.active;

  esi_ctrl #(
    .AXIS_COUNT (AXIS_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .debounce  (debounce),
    .slot_free (slot_free),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register
  assign slot_free = !out_valid || result_out.ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= res_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (slot_free && res_valid) begin
      out_res <= res;
    end
  end

  assign result_out.valid                = out_valid;
  assign result_out.safety_mode          = out_res.mode;
  assign result_out.motion_allowed       = (out_res.mode == MODE_NORMAL) ||
                                           (out_res.mode == MODE_HOMING);
  assign result_out.latch_bits           = out_res.latch;
  assign result_out.any_latch            = |out_res.latch;
  assign result_out.reply_flag           = out_res.reply;
  assign result_out.clear_endstop_strobe = out_res.clr_end;
  assign result_out.clear_drift_strobe   = out_res.clr_drift;

  // checks
  localparam logic [CHANNELS-1:0] EXIST_CHK = exist_mask(AXIS_COUNT);

  // the sequencer is busy in the cycle after it takes an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_in.valid && item_in.ready) |=> !item_in.ready)
    else $error("item taken while the previous one is still in work");

  // a successful try clear leaves a clean, normal state
  a_tryclear_clean: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.clear_endstop_strobe) |->
      (result_out.clear_drift_strobe && result_out.reply_flag &&
       result_out.latch_bits == '0 && result_out.safety_mode == MODE_NORMAL))
    else $error("try clear strobe with residual state");

  // channels of absent axes never latch
  a_no_ghost_latch: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> ((result_out.latch_bits & ~EXIST_CHK) == '0))
    else $error("latch set on a channel that does not exist");

endmodule

@@ tb/esi_status_checker.sv @@
`timescale 1ns / 1ps

module esi_status_checker import esi_pkg::*; #(
  parameter int AXIS_COUNT = AXIS_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  esi_in_if    item_in,
  esi_out_if   result_out,
  esi_cfg_if   cfg,
  output int   fail_count,
  output int   outstanding
);

  // one status item as the block should report it
  typedef struct packed {
    mode_t               mode;
    logic                motion;
    logic [CHANNELS-1:0] latch;
    logic                any;
    logic                reply;
    logic                clr_end;
    logic                clr_drift;
  } status_t;

  // interlock state as tracked on this side
  logic [DEB_W-1:0]    deb;
  mode_t               mode;
  logic                homing_on;
  logic                release_on;
  logic [CHANNELS-1:0] pend;
  logic [CHANNELS-1:0] latch;
  logic [TIME_W-1:0]   edge_at [CHANNELS];
  status_t             status_due [$];
  int                  errs = 0;

  function automatic logic chan_live(input int ch);
    return (ch < CHANNELS) && ((ch / 2) < AXIS_COUNT);
  endfunction

  function automatic logic [CHANNELS-1:0] live_mask();
    logic [CHANNELS-1:0] m;
    for (int i = 0; i < CHANNELS; i++) begin
      m[i] = chan_live(i);
    end
    return m;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errs++;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      report($sformatf("%s expected %0h, got %0h", name, want, got));
    end
  endtask

  task automatic drop_all(input logic times_too);
    pend  = '0;
    latch = '0;
    if (times_too) begin
      for (int i = 0; i < CHANNELS; i++) begin
        edge_at[i] = '0;
      end
    end
  endtask

  // debounced latch walk over every live pending channel
  task automatic run_poll(input logic [TIME_W-1:0] now, input logic [CHANNELS-1:0] lv,
                          input logic drift);
    if (release_on) begin
      drop_all(1'b0);
    end else begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        if (chan_live(ch) && pend[ch] && now >= edge_at[ch] &&
            (now - edge_at[ch]) >= TIME_W'(deb)) begin
          if (lv[ch]) begin
            latch[ch] = 1'b1;
            if (!homing_on) begin
              mode = MODE_ESTOP;
            end else if (mode == MODE_NORMAL) begin
              mode = MODE_HOMING;
            end
          end
          pend[ch] = 1'b0;
        end
      end
      if (drift && (mode == MODE_NORMAL || mode == MODE_HOMING)) begin
        mode = MODE_FAULT;
      end
    end
  endtask

  // effect of one event on the state, and the status it should produce
  task automatic apply_event(input item_t it, output status_t st);
    int   ch;
    logic live;
    logic reply;
    logic s_end;
    logic s_drift;
    ch      = int'(it.axis_index) * 2 + int'(it.end_select);
    live    = chan_live(ch);
    reply   = 1'b0;
    s_end   = 1'b0;
    s_drift = 1'b0;
    case (it.opcode)
      OP_NOTIFY: begin
        if (live) begin
          pend[ch]    = 1'b1;
          edge_at[ch] = it.time_us;
        end
      end
      OP_POLL: begin
        run_poll(it.time_us, it.pressed_levels, it.drift_present);
      end
      OP_HOMING: begin
        homing_on = it.active;
        if (it.active && mode == MODE_NORMAL) begin
          mode = MODE_HOMING;
        end else if (!it.active && mode == MODE_HOMING) begin
          mode = MODE_NORMAL;
        end
      end
      OP_RELEASE: begin
        release_on = it.active;
        if (it.active) begin
          drop_all(1'b0);
          if (mode == MODE_ESTOP) begin
            mode = MODE_NORMAL;
          end
        end
      end
      OP_ESTOP: begin
        mode = MODE_ESTOP;
      end
      OP_FAULT: begin
        if (mode != MODE_FAULT && mode != MODE_ESTOP) begin
          mode = MODE_FAULT;
        end
      end
      OP_TRYCLEAR: begin
        // only succeeds with no live endstop pressed
        if ((it.pressed_levels & live_mask()) == '0) begin
          drop_all(1'b1);
          s_end     = 1'b1;
          s_drift   = 1'b1;
          mode      = MODE_NORMAL;
          homing_on = 1'b0;
          reply     = 1'b1;
        end
      end
      OP_QUERY: begin
        if (live) begin
          reply = latch[ch];
        end
      end
      OP_CLEAR, OP_CONSUME: begin
        if (live) begin
          if (it.opcode == OP_CONSUME) begin
            reply = latch[ch];
          end
          latch[ch]   = 1'b0;
          pend[ch]    = 1'b0;
          edge_at[ch] = '0;
        end
      end
      OP_CLEARPEND: begin
        if (live) begin
          pend[ch]    = 1'b0;
          edge_at[ch] = '0;
        end
      end
      OP_FORCE: begin
        drop_all(1'b1);
        s_drift   = 1'b1;
        mode      = MODE_NORMAL;
        homing_on = 1'b0;
      end
      default: begin
      end
    endcase
    st.mode      = mode;
    st.motion    = (mode == MODE_NORMAL || mode == MODE_HOMING);
    st.latch     = latch;
    st.any       = |latch;
    st.reply     = reply;
    st.clr_end   = s_end;
    st.clr_drift = s_drift;
  endtask

  // watch all three channels, compare before predicting
  always @(posedge clk) begin : track
    item_t   seen;
    status_t want;
    status_t got;
    if (rst) begin
      deb        = DEB_RESET;
      mode       = MODE_NORMAL;
      homing_on  = 1'b0;
      release_on = 1'b0;
      drop_all(1'b1);
      status_due.delete();
    end else begin
      if (result_out.valid && result_out.ready) begin
        got.mode      = mode_t'(result_out.safety_mode);
        got.motion    = result_out.motion_allowed;
        got.latch     = result_out.latch_bits;
        got.any       = result_out.any_latch;
        got.reply     = result_out.reply_flag;
        got.clr_end   = result_out.clear_endstop_strobe;
        got.clr_drift = result_out.clear_drift_strobe;
        if (status_due.size() == 0) begin
          report("status item arrived with nothing expected");
        end else begin
          want = status_due.pop_front();
          check_field("safety_mode", 16'(want.mode), 16'(got.mode));
          check_field("motion_allowed", 16'(want.motion), 16'(got.motion));
          check_field("latch_bits", 16'(want.latch), 16'(got.latch));
          check_field("any_latch", 16'(want.any), 16'(got.any));
          check_field("reply_flag", 16'(want.reply), 16'(got.reply));
          check_field("clear_endstop_strobe", 16'(want.clr_end), 16'(got.clr_end));
          check_field("clear_drift_strobe", 16'(want.clr_drift), 16'(got.clr_drift));
        end
      end
      if (cfg.valid && cfg.ready) begin
        deb = cfg.settle_time;
      end
      if (item_in.valid && item_in.ready) begin
        seen.opcode         = item_in.opcode;
        seen.axis_index     = item_in.axis_index;
        seen.end_select     = item_in.end_select;
        seen.time_us        = item_in.time_us;
        seen.pressed_levels = item_in.pressed_levels;
        seen.drift_present  = item_in.drift_present;
        seen.active         = item_in.active;
        apply_event(seen, want);
        status_due.push_back(want);
      end
    end
    fail_count  <= errs;
    outstanding <= status_due.size();
  end

endmodule

@@ tb/tb_endstop_safety_interlock.sv @@
`timescale 1ns / 1ps

module tb_endstop_safety_interlock;
  import esi_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASE_ITEMS = 105;

  logic clk;
  logic rst;

  esi_in_if  item_in ();
  esi_out_if result_out ();
  esi_cfg_if cfg ();

  int fail_count;
  int outstanding;
  int idle_cycles;

  // stimulus-side knowledge: time base and current debounce
  logic [TIME_W-1:0] clock_now;
  logic [DEB_W-1:0]  deb_set;
  bit                calm;
  bit                steady;

  endstop_safety_interlock i_dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .result_out (result_out),
    .cfg        (cfg)
  );

  esi_status_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .item_in     (item_in),
    .result_out  (result_out),
    .cfg         (cfg),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short pauses, now and then a long one
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 50);
  endfunction

  // status receiver with random stalls
  initial begin : result_sink
    int hold;
    result_out.ready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (steady || $urandom_range(0, 99) < 60) begin
        result_out.ready <= 1'b1;
        hold = $urandom_range(0, 8);
      end else begin
        result_out.ready <= 1'b0;
        hold = idle_span();
      end
    end
  end

  // no progress on any channel for too long ends the run
  always @(posedge clk) begin
    if (rst || (item_in.valid && item_in.ready) || (result_out.valid && result_out.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** endstop_safety_interlock: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one item, keep valid high across back-to-back items
  task automatic push_event(input item_t it);
    int gap;
    gap = calm ? 0 : idle_span();
    if (gap > 0) begin
      item_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_in.valid          <= 1'b1;
    item_in.opcode         <= it.opcode;
    item_in.axis_index     <= it.axis_index;
    item_in.end_select     <= it.end_select;
    item_in.time_us        <= it.time_us;
    item_in.pressed_levels <= it.pressed_levels;
    item_in.drift_present  <= it.drift_present;
    item_in.active         <= it.active;
    @(posedge clk);
    while (!item_in.ready) @(posedge clk);
  endtask

  task automatic send_event(input logic [3:0] op, input int axis, input logic sel,
                            input logic [TIME_W-1:0] t, input logic [CHANNELS-1:0] lv,
                            input logic drift, input logic act);
    item_t it;
    it.opcode         = op;
    it.axis_index     = AXIS_W'(axis);
    it.end_select     = sel;
    it.time_us        = t;
    it.pressed_levels = lv;
    it.drift_present  = drift;
    it.active         = act;
    push_event(it);
  endtask

  // hold the sender until every status item has come back
  task automatic wait_for_results();
    item_in.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_debounce(input logic [DEB_W-1:0] v);
    wait_for_results();
    cfg.valid       <= 1'b1;
    cfg.settle_time <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    deb_set = v;
  endtask

  // mostly well-formed events on live channels, notify and poll the most, some noise
  task automatic make_random_event(output item_t it);
    int          r;
    int          s;
    int unsigned adv;
    it.opcode         = 4'($urandom);
    it.axis_index     = AXIS_W'($urandom);
    it.end_select     = 1'($urandom);
    it.time_us        = TIME_W'({$urandom, $urandom});
    it.pressed_levels = CHANNELS'($urandom);
    it.drift_present  = 1'($urandom);
    it.active         = 1'($urandom);
    r = $urandom_range(0, 99);
    if (r >= 5) begin
      if ($urandom_range(0, 9) != 0) begin
        it.axis_index = AXIS_W'($urandom_range(0, AXIS_COUNT_DEF - 1));
      end
      if (r < 32) begin
        it.opcode = OP_NOTIFY;
        if ($urandom_range(0, 19) == 0) begin
          it.time_us = clock_now + TIME_W'($urandom_range(1, 5000));
        end else begin
          it.time_us = clock_now - TIME_W'($urandom_range(0, 3));
        end
      end else if (r < 56) begin
        it.opcode = OP_POLL;
        s = $urandom_range(0, 9);
        if (s < 4) begin
          adv = $urandom_range(0, deb_set);
        end else if (s < 8) begin
          adv = deb_set + $urandom_range(0, 20);
        end else begin
          adv = $urandom_range(0, 3 * deb_set + 100);
        end
        clock_now  = clock_now + TIME_W'(adv);
        it.time_us = clock_now;
        s = $urandom_range(0, 9);
        if (s < 2) begin
          it.pressed_levels = '1;
        end else if (s == 2) begin
          it.pressed_levels = '0;
        end
        it.drift_present = ($urandom_range(0, 11) == 0);
      end else if (r < 61) begin
        it.opcode = OP_HOMING;
      end else if (r < 65) begin
        it.opcode = OP_RELEASE;
        it.active = ($urandom_range(0, 3) == 0);
      end else if (r < 68) begin
        it.opcode = OP_ESTOP;
      end else if (r < 71) begin
        it.opcode = OP_FAULT;
      end else if (r < 77) begin
        it.opcode = OP_TRYCLEAR;
        if ($urandom_range(0, 1) == 0) begin
          it.pressed_levels = '0;
        end
      end else if (r < 83) begin
        it.opcode = OP_QUERY;
      end else if (r < 87) begin
        it.opcode = OP_CLEAR;
      end else if (r < 92) begin
        it.opcode = OP_CONSUME;
      end else if (r < 96) begin
        it.opcode = OP_CLEARPEND;
      end else if (r < 98) begin
        it.opcode = OP_FORCE;
      end else begin
        it.opcode = 4'(OP_FORCE) + 4'($urandom_range(1, 4));
      end
    end
  endtask

  task automatic run_random_events(input int count);
    item_t it;
    for (int n = 0; n < count; n++) begin
      if (n % 25 == 0) begin
        calm   = ($urandom_range(0, 3) == 0);
        steady = ($urandom_range(0, 3) == 0);
      end
      if (n == count / 2) begin
        wait_for_results();
      end
      make_random_event(it);
      push_event(it);
    end
  endtask

  // edges, ranges and each corner of the interlock at the reset debounce
  task automatic run_directed_events();
    send_event(OP_QUERY, 0, 1'b0, '0, '0, 1'b0, 1'b0);
    send_event(OP_NOTIFY, 0, 1'b0, TIME_W'(100), '0, 1'b0, 1'b0);
    // one microsecond short of the debounce, then exactly on it
    send_event(OP_POLL, 0, 1'b0, TIME_W'(2099), '1, 1'b0, 1'b0);
    send_event(OP_POLL, 0, 1'b0, TIME_W'(2100), CHANNELS'(1), 1'b0, 1'b0);
    send_event(OP_QUERY, 0, 1'b0, '0, '0, 1'b0, 1'b0);
    // axis outside the arm
    send_event(OP_QUERY, 15, 1'b1, '1, '1, 1'b1, 1'b1);
    send_event(OP_NOTIFY, AXIS_COUNT_DEF, 1'b0, '0, '0, 1'b0, 1'b0);
    send_event(OP_CONSUME, 0, 1'b0, '0, '0, 1'b0, 1'b0);
    // try clear while pressed, then with nothing pressed
    send_event(OP_TRYCLEAR, 0, 1'b0, '0, CHANNELS'(1) << (CHANNELS - 1), 1'b0, 1'b0);
    send_event(OP_TRYCLEAR, 0, 1'b0, '0, '0, 1'b0, 1'b0);
    send_event(OP_HOMING, 0, 1'b0, '0, '0, 1'b0, 1'b1);
    // edge in the future stays pending
    send_event(OP_NOTIFY, AXIS_COUNT_DEF - 1, 1'b1, '1, '0, 1'b0, 1'b0);
    send_event(OP_POLL, 0, 1'b0, TIME_W'(5), '1, 1'b0, 1'b0);
    send_event(OP_NOTIFY, 2, 1'b1, '0, '0, 1'b0, 1'b0);
    send_event(OP_POLL, 0, 1'b0, TIME_W'(3000), CHANNELS'(32), 1'b1, 1'b0);
    send_event(OP_FAULT, 0, 1'b0, '0, '0, 1'b0, 1'b0);
    send_event(OP_ESTOP, 0, 1'b0, '0, '0, 1'b0, 1'b0);
    // manual release on: poll drops everything and skips drift
    send_event(OP_RELEASE, 0, 1'b0, '0, '0, 1'b0, 1'b1);
    send_event(OP_NOTIFY, 1, 1'b0, '0, '0, 1'b0, 1'b0);
    send_event(OP_POLL, 0, 1'b0, TIME_W'(9000), '1, 1'b1, 1'b0);
    send_event(OP_RELEASE, 0, 1'b0, '0, '0, 1'b0, 1'b0);
    send_event(OP_CLEARPEND, AXIS_COUNT_DEF - 1, 1'b1, '0, '0, 1'b0, 1'b0);
    send_event(OP_CLEAR, 0, 1'b1, '0, '0, 1'b0, 1'b0);
    send_event(OP_FORCE, 0, 1'b0, '0, '0, 1'b0, 1'b0);
    // unused opcodes only report status
    send_event(4'(OP_FORCE) + 4'd1, 3, 1'b0, '1, '1, 1'b1, 1'b1);
    send_event(4'(OP_FORCE) + 4'd4, 0, 1'b1, '0, '0, 1'b0, 1'b0);
    send_event(OP_HOMING, 0, 1'b0, '0, '0, 1'b0, 1'b0);
  endtask

  initial begin
    logic [DEB_W-1:0] deb_plan [7];
    rst                    <= 1'b1;
    item_in.valid          <= 1'b0;
    item_in.opcode         <= '0;
    item_in.axis_index     <= '0;
    item_in.end_select     <= 1'b0;
    item_in.time_us        <= '0;
    item_in.pressed_levels <= '0;
    item_in.drift_present  <= 1'b0;
    item_in.active         <= 1'b0;
    cfg.valid              <= 1'b0;
    cfg.settle_time        <= '0;
    calm      = 1'b0;
    steady    = 1'b0;
    deb_set   = DEB_RESET;
    clock_now = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed_events();

    // debounce settings: extremes, a large in-range value, reset value and random ones
    deb_plan[0] = '0;
    deb_plan[1] = DEB_W'(1);
    deb_plan[2] = '1;
    deb_plan[3] = DEB_W'(1000000);
    deb_plan[4] = DEB_W'($urandom_range(0, 4000));
    deb_plan[5] = DEB_RESET;
    deb_plan[6] = DEB_W'($urandom);
    for (int p = 0; p < 7; p++) begin
      set_debounce(deb_plan[p]);
      clock_now = TIME_W'({$urandom, $urandom});
      run_random_events(PHASE_ITEMS);
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** endstop_safety_interlock: PASSED **");
    end else begin
      $display("** endstop_safety_interlock: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/esi_pkg.sv
rtl/core/esi_in_if.sv
rtl/core/esi_out_if.sv
rtl/core/esi_cfg_if.sv
rtl/core/esi_age_cmp.sv
rtl/core/esi_ctrl.sv
rtl/core/endstop_safety_interlock.sv
tb/esi_status_checker.sv
tb/tb_endstop_safety_interlock.sv
